FILE: src/assert_macros.svh
// Assertion macros shared by the monitor's RTL files.
// Depends on nothing; included inside the module bodies that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/cva_pkg.sv
// Types and constants of the cell voltage alarm controller.
// Used by cva_rx_parser and by the top level; depends on nothing.
package cva_pkg;

    // Field widths.
    localparam int MODE_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int ADC_W   = 10;
    localparam int MV_W    = 13;
    localparam int LIMIT_W = 14;
    localparam int TICK_W  = 11;
    localparam int FIELD_CELLS = 4;

    // Item kinds.
    localparam logic [MODE_W-1:0] MODE_BYTE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CELLS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MV  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TICK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd2;

    // Reset values.
    localparam logic [MV_W-1:0]    REF_MV_RESET  = 13'd4340;
    localparam logic [TICK_W-1:0]  ON_TICK_RESET = 11'd1000;
    localparam logic [TICK_W-1:0]  PERIOD_RESET  = 11'd2000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 14'd3300;

    // Command characters.
    localparam logic [BYTE_W-1:0] CHAR_V     = 8'h76;
    localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] rx_byte;
        logic [ADC_W-1:0]  cell_1_adc;
        logic [ADC_W-1:0]  cell_2_adc;
        logic [ADC_W-1:0]  cell_3_adc;
        logic [ADC_W-1:0]  cell_4_adc;
    } t_in_item;

    typedef struct packed {
        logic               limit_updated;
        logic [LIMIT_W-1:0] limit_mv;
        logic               voltage_low;
        logic               alarm_active;
        logic               tone_enable;
        logic               indicator_on;
        logic [MV_W-1:0]    cell_1_mv;
        logic [MV_W-1:0]    cell_2_mv;
        logic [MV_W-1:0]    cell_3_mv;
        logic [MV_W-1:0]    cell_4_mv;
    } t_out_item;

    // Parser status towards the top level.
    typedef struct packed {
        logic               done;
        logic [LIMIT_W-1:0] value;
    } t_parse_res;

endpackage

FILE: src/cva_rx_parser.sv
// Serial command parser for the limit command: v, colon, four digits, newline.
// Depends on cva_pkg and assert_macros.svh.
module cva_rx_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_byte_valid,
    input  logic [cva_pkg::BYTE_W-1:0] i_byte,
    output cva_pkg::t_parse_res        o_res
);
    import cva_pkg::*;
    `include "assert_macros.svh"

    localparam int POS_W = 3;
    localparam logic [POS_W-1:0] POS_WAIT_V     = 3'd0;
    localparam logic [POS_W-1:0] POS_WAIT_COLON = 3'd1;
    localparam logic [POS_W-1:0] POS_DIGIT_1    = 3'd2;
    localparam logic [POS_W-1:0] POS_DIGIT_2    = 3'd3;
    localparam logic [POS_W-1:0] POS_DIGIT_3    = 3'd4;
    localparam logic [POS_W-1:0] POS_DIGIT_4    = 3'd5;
    localparam logic [POS_W-1:0] POS_WAIT_NL    = 3'd6;

    logic [POS_W-1:0]   r_pos, n_pos;
    logic [LIMIT_W-1:0] r_acc, n_acc;
    logic               is_digit;
    logic [3:0]         digit;
    logic [LIMIT_W+3:0] acc_x10;
    logic               done;

    // Decode the byte and form the accumulator times ten plus the digit.
    always_comb begin
        is_digit = i_byte inside {[CHAR_0:CHAR_9]};
        digit    = 4'(i_byte - CHAR_0);
        acc_x10  = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + (LIMIT_W+4)'(digit);
    end

    // Next position; any unexpected byte returns the parser to the start.
    always_comb begin
        n_pos = POS_WAIT_V;
        n_acc = r_acc;
        done  = 1'b0;
        case (r_pos)
            POS_WAIT_V: begin
                if (i_byte == CHAR_V) n_pos = POS_WAIT_COLON;
            end
            POS_WAIT_COLON: begin
                if (i_byte == CHAR_COLON) n_pos = POS_DIGIT_1;
            end
            POS_DIGIT_1: begin
                if (is_digit) begin
                    n_pos = POS_DIGIT_2;
                    n_acc = LIMIT_W'(digit);
                end
            end
            POS_DIGIT_2, POS_DIGIT_3, POS_DIGIT_4: begin
                if (is_digit) begin
                    n_pos = r_pos + 3'd1;
                    n_acc = acc_x10[LIMIT_W-1:0];
                end
            end
            POS_WAIT_NL: begin
                if (i_byte == CHAR_NL) done = 1'b1;
            end
            default: begin
                n_pos = POS_WAIT_V;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_WAIT_V;
            r_acc <= '0;
        end else if (i_byte_valid) begin
            r_pos <= n_pos;
            r_acc <= n_acc;
        end
    end

    assign o_res.done  = done;
    assign o_res.value = r_acc;

    `ASSERT_ALWAYS(a_pos_in_range, i_clk, i_rst_n, r_pos <= POS_WAIT_NL,
        "parser position left the command range")

endmodule

FILE: src/cell_voltage_alarm_controller.sv
// Cell voltage alarm controller: an accepted input transaction passes through the input register,
// then its result is held in the result register.
// Throughput is one transaction per cycle; the input register keeps taking a
// transaction while a result waits, and stalls only when both are full.
// Synchronous active-low reset clears control state, the limit (3300 mV) and
// the configuration registers to their documented values.
// Depends on cva_pkg, cva_rx_parser and assert_macros.svh.
module cell_voltage_alarm_controller #(
    parameter int ADC_BITS   = 10,
    parameter int CELL_COUNT = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  cva_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output cva_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_we,
    input  logic [cva_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cva_pkg::MV_W-1:0]      i_cfg_data
);
    import cva_pkg::*;
    `include "assert_macros.svh"

    localparam int PROD_W    = ADC_W + MV_W;
    localparam int MASK_BITS = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
    localparam logic [ADC_W-1:0] CODE_MASK = ADC_W'((64'd1 << MASK_BITS) - 64'd1);
    localparam logic [PROD_W-1:0] MV_MAX = PROD_W'((64'd1 << MV_W) - 64'd1);

    // Configuration registers.
    logic [MV_W-1:0]   r_ref_mv;
    logic [TICK_W-1:0] r_on_tick;
    logic [TICK_W-1:0] r_period;

    // Handshake and pipeline registers.
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      advance;

    // Block state.
    logic [LIMIT_W-1:0] r_limit, n_limit;
    logic [TICK_W-1:0]  r_count, n_count;
    logic               r_alarm_en, n_alarm_en;
    logic               r_tone_on, n_tone_on;
    logic               r_ind_high, n_ind_high;
    logic               r_low_flag, n_low_flag;
    logic [MV_W-1:0]    r_cells_mv [FIELD_CELLS];
    logic [MV_W-1:0]    n_cells_mv [FIELD_CELLS];

    logic [ADC_W-1:0] adc [FIELD_CELLS];
    logic [MV_W-1:0]  lane_mv [FIELD_CELLS];
    logic [FIELD_CELLS-1:0] lane_low;
    logic             is_byte, is_cells, is_tick;
    t_parse_res       parse;

    // Configuration writes; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_mv  <= REF_MV_RESET;
            r_on_tick <= ON_TICK_RESET;
            r_period  <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REF_MV:  r_ref_mv  <= i_cfg_data;
                CFG_ON_TICK: r_on_tick <= i_cfg_data[TICK_W-1:0];
                CFG_PERIOD:  r_period  <= i_cfg_data[TICK_W-1:0];
                default:     ;
            endcase
        end
    end

    // The input register moves on whenever the result register is free or drains.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    assign is_byte  = advance && (r_in.mode == MODE_BYTE);
    assign is_cells = advance && (r_in.mode == MODE_CELLS);
    assign is_tick  = advance && (r_in.mode == MODE_TICK);

    cva_rx_parser u_rx_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (is_byte),
        .i_byte       (r_in.rx_byte),
        .o_res        (parse)
    );

    // Gather the ADC codes so that each lane sees its own.
    always_comb begin
        adc[0] = r_in.cell_1_adc;
        adc[1] = r_in.cell_2_adc;
        adc[2] = r_in.cell_3_adc;
        adc[3] = r_in.cell_4_adc;
    end

    // One scaling lane per cell: code times reference, shifted by the ADC width.
    for (genvar i = 0; i < FIELD_CELLS; i++) begin : g_lane
        if (i < CELL_COUNT) begin : g_active
            logic [PROD_W-1:0] prod;
            logic [PROD_W-1:0] shifted;
            always_comb begin
                prod        = PROD_W'(adc[i] & CODE_MASK) * PROD_W'(r_ref_mv);
                shifted     = prod >> ADC_BITS;
                lane_mv[i]  = (shifted > MV_MAX) ? MV_MAX[MV_W-1:0] : shifted[MV_W-1:0];
                lane_low[i] = LIMIT_W'(lane_mv[i]) < r_limit;
            end
        end else begin : g_unused
            assign lane_mv[i]  = '0;
            assign lane_low[i] = 1'b0;
        end
    end

    // Next state for the item leaving the input register.
    always_comb begin
        n_limit    = r_limit;
        n_count    = r_count;
        n_alarm_en = r_alarm_en;
        n_tone_on  = r_tone_on;
        n_ind_high = r_ind_high;
        n_low_flag = r_low_flag;
        n_cells_mv = r_cells_mv;

        if (is_byte && parse.done) begin
            n_limit = parse.value;
        end

        if (is_cells) begin
            n_cells_mv = lane_mv;
            n_low_flag = |lane_low;
            if (|lane_low) begin
                n_alarm_en = 1'b1;
            end else if (r_alarm_en) begin
                n_alarm_en = 1'b0;
                n_tone_on  = 1'b0;
                n_ind_high = 1'b0;
            end
        end

        // Tone cadence: the count-zero test wins over the on-point.
        if (is_tick && r_alarm_en) begin
            if (r_count < r_period) begin
                if (r_count == '0) begin
                    n_tone_on  = 1'b0;
                    n_ind_high = 1'b0;
                end else if (r_count == r_on_tick) begin
                    n_tone_on  = 1'b1;
                    n_ind_high = 1'b1;
                end
                n_count = r_count + 1'b1;
            end else begin
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= LIMIT_RESET;
            r_count    <= '0;
            r_alarm_en <= 1'b0;
            r_tone_on  <= 1'b0;
            r_ind_high <= 1'b0;
            r_low_flag <= 1'b0;
            r_cells_mv <= '{default: '0};
        end else begin
            r_limit    <= n_limit;
            r_count    <= n_count;
            r_alarm_en <= n_alarm_en;
            r_tone_on  <= n_tone_on;
            r_ind_high <= n_ind_high;
            r_low_flag <= n_low_flag;
            r_cells_mv <= n_cells_mv;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.limit_updated <= is_byte && parse.done;
            r_out.limit_mv      <= n_limit;
            r_out.voltage_low   <= n_low_flag;
            r_out.alarm_active  <= n_alarm_en;
            r_out.tone_enable   <= n_tone_on;
            r_out.indicator_on  <= n_ind_high;
            r_out.cell_1_mv     <= n_cells_mv[0];
            r_out.cell_2_mv     <= n_cells_mv[1];
            r_out.cell_3_mv     <= n_cells_mv[2];
            r_out.cell_4_mv     <= n_cells_mv[3];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `ASSERT_ALWAYS(a_tone_matches_ind, i_clk, i_rst_n, r_tone_on == r_ind_high,
        "tone and indicator disagree")
    `ASSERT_ALWAYS(a_alarm_follows_low, i_clk, i_rst_n, r_alarm_en == r_low_flag,
        "alarm enable differs from the last low-voltage result")
    `ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_valid && !advance,
        r_in_valid && $stable(r_in), "stalled input register lost its transaction")

endmodule
